// ===== hw/rtl/wfs_pkg.sv =====
package wfs_pkg;

    // Position format: signed Q16.16 held at POS_BITS bits (16..48)
    localparam int POS_BITS = 32;
    // pos - 2*tf needs 34 signed bits; work at least that wide
    localparam int CALC_W = (POS_BITS > 34) ? POS_BITS : 34;
    localparam logic signed [CALC_W-1:0] POS_MAX =
        CALC_W'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
    localparam logic signed [CALC_W-1:0] POS_MIN = -POS_MAX - CALC_W'(1);

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 31;
    localparam int SC_W      = 8;
    localparam int TF_W      = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_NEGATIVE   = 2'd2;
    localparam logic [SC_W-1:0] SC_RESET = 8'd1;
    localparam logic [TF_W-1:0] TF_RESET = 31'd65536;

    // System states
    localparam logic [3:0] ST_IDLE_WELD = 4'd1;
    localparam logic [3:0] ST_PRE       = 4'd2;
    localparam logic [3:0] ST_RUN       = 4'd4;
    localparam logic [3:0] ST_DELAY_GAS = 4'd7;
    localparam logic [3:0] ST_ALARM     = 4'd8;
    localparam logic [3:0] ST_RESET     = 4'd9;

    // Alarm codes
    localparam logic [2:0] ALM_NONE       = 3'd0;
    localparam logic [2:0] ALM_BUS_LOST   = 3'd1;
    localparam logic [2:0] ALM_HAND_SHORT = 3'd2;
    localparam logic [2:0] ALM_SHORT      = 3'd3;
    localparam logic [2:0] ALM_ARC_BROKEN = 3'd4;
    localparam logic [2:0] ALM_MACHINE    = 3'd5;

    // Axis commands
    localparam logic [1:0] CMD_NONE      = 2'd0;
    localparam logic [1:0] CMD_WELD_MOVE = 2'd1;
    localparam logic [1:0] CMD_IDLE      = 2'd2;

    // Digital input bits
    localparam int DI_SHORT_N     = 6;
    localparam int DI_ARC_LOST    = 14;
    localparam int DI_MACHINE_ERR = 5;

    localparam logic [31:0] UPTIME_MIN   = 32'd2;
    localparam int          HB_PER_SLAVE = 3;

    // Retract speed = round(3.33 * tf) = (333*tf + 50) / 100, built from the
    // two 16-bit halves of tf so each divide by 100 works on less than 2^26
    localparam int VEL_NUM  = 333;
    localparam int VEL_DEN  = 100;
    localparam int VEL_RND  = 50;
    localparam int TF_LO_W  = 16;
    localparam int SPD_A_W  = 24;   // 333 * (2^15-1) < 2^24
    localparam int SPD_C_W  = 25;   // 99*2^16 + 333*(2^16-1) + 50 < 2^25
    localparam int SPD_QA_W = 17;   // high-half quotient < 2^17
    localparam int SPD_QC_W = 19;   // low-half quotient < 2^19
    localparam int RCP_W    = 26;
    localparam int RCP_SH   = 32;
    localparam int SPD_AP_W = SPD_A_W + RCP_W;
    localparam int SPD_CP_W = SPD_C_W + RCP_W;
    // ceil(2^32 / 100): exact x / 100 for any x < 2^30
    localparam logic [RCP_W-1:0] RCP_100 = 26'd42949673;
    localparam int QUO_W    = 33;   // speed < 2^33
    localparam int REM_W    = 7;    // remainder < 100
    localparam int STEP_W   = 3;
    localparam logic [STEP_W-1:0] SPD_STEPS = 3'd4;
    localparam logic [QUO_W-1:0] MAG_RESET =
        QUO_W'((65536 * VEL_NUM + VEL_RND) / VEL_DEN);

    typedef struct packed {
        logic [31:0]        uptime;
        logic [9:0]         heartbeat_count;
        logic [15:0]        digital_inputs;
        logic               current_enabled;
        logic [3:0]         system_state;
        logic signed [31:0] axis_position;
    } in_word_t;

    typedef struct packed {
        logic [3:0]         new_system_state;
        logic [2:0]         alarm_code;
        logic               alarm_written;
        logic [1:0]         axis_command;
        logic               velocity_written;
        logic signed [31:0] target_velocity;
    } out_word_t;

endpackage

// ===== hw/rtl/wfs_if.sv =====
interface wfs_in_if;
    import wfs_pkg::*;

    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wfs_out_if;
    import wfs_pkg::*;

    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/weld_fault_supervisor.sv =====
// Welding fault supervisor, one input word per control tick, one result word
// back. Each word goes through an input register, one pass of check logic and
// an output register, so words stream at one per clock while the result side
// is taken and no speed divide runs; a stalled result holds off the input only
// once the input register is also full. Checks run only when uptime is
// above 2: heartbeat loss (count != 3 * slave_count) raises bus-lost and ends
// the tick, otherwise short circuit, arc broken and machine error are checked
// in that order, each seeing the state left by the one before, and the last
// alarm wins. A short circuit in idle-weld arms the arc-axis retract: the same
// tick latches an end point two transfer units back, later ticks drive the axis
// backward at round(3.33 * transfer_factor), and on arrival stop it and report
// state reset. The retract speed is a constant of transfer_factor and is worked
// out by a four-step reciprocal-multiply divide by 100 after every transfer_factor
// write; din.ready stays low from that write until the divide is done.
// Configuration writes take effect at once otherwise and are meant only while
// idle.
module weld_fault_supervisor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [wfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wfs_pkg::CFG_W-1:0]     cfg_wdata,
    wfs_in_if.sink                        din,
    wfs_out_if.source                     dout
);
    import wfs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_MOVE = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    // ---------------- configuration registers ----------------
    logic [SC_W-1:0] slave_count_reg;
    logic [TF_W-1:0] transfer_factor_reg;
    logic            axis_negative_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_count_reg     <= SC_RESET;
            transfer_factor_reg <= TF_RESET;
            axis_negative_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLAVE_COUNT:     slave_count_reg     <= cfg_wdata[SC_W-1:0];
                CFG_TRANSFER_FACTOR: transfer_factor_reg <= cfg_wdata[TF_W-1:0];
                CFG_AXIS_NEGATIVE:   axis_negative_reg   <= cfg_wdata[0];
                default:             ;
            endcase
        end
    end

    // ---------------- retract speed: (333*tf + 50) / 100 ----------------
    // tf = hi*2^16 + lo. With a = 333*hi = 100*qa + ra and b = 333*lo + 50,
    // the speed is qa*2^16 + (ra*2^16 + b) / 100. Both divides by 100 are
    // reciprocal multiplies. The stages follow transfer_factor_reg one step
    // per clock; the speed register loads on the last count of the sequence.
    logic                 tf_write;
    logic                 div_busy;
    logic [STEP_W-1:0]    div_count_reg;
    logic [STEP_W-1:0]    div_count_next;
    logic [SPD_A_W-1:0]   spd_a_reg;
    logic [SPD_A_W-1:0]   spd_a_next;
    logic [SPD_C_W-1:0]   spd_b_reg;
    logic [SPD_C_W-1:0]   spd_b_next;
    logic [SPD_QA_W-1:0]  spd_qa_reg;
    logic [SPD_QA_W-1:0]  spd_qa_next;
    logic [SPD_C_W-1:0]   spd_c_reg;
    logic [SPD_C_W-1:0]   spd_c_next;
    logic [QUO_W-1:0]     vel_mag_reg;
    logic [QUO_W-1:0]     vel_mag_next;
    logic [SPD_AP_W-1:0]  spd_qa_prod;
    logic [SPD_CP_W-1:0]  spd_qc_prod;
    logic [REM_W-1:0]     spd_ra;
    logic [QUO_W-1:0]     vel_mag;

    assign tf_write       = cfg_we && (cfg_index == CFG_TRANSFER_FACTOR);
    assign div_busy       = (div_count_reg != '0);
    assign div_count_next = tf_write ? SPD_STEPS
                          : (div_busy ? div_count_reg - STEP_W'(1) : div_count_reg);

    assign spd_a_next  = SPD_A_W'(transfer_factor_reg[TF_W-1:TF_LO_W]) * SPD_A_W'(VEL_NUM);
    assign spd_b_next  = SPD_C_W'(transfer_factor_reg[TF_LO_W-1:0]) * SPD_C_W'(VEL_NUM)
                         + SPD_C_W'(VEL_RND);
    assign spd_qa_prod = SPD_AP_W'(spd_a_reg) * SPD_AP_W'(RCP_100);
    assign spd_qa_next = spd_qa_prod[RCP_SH +: SPD_QA_W];
    assign spd_ra      = REM_W'(spd_a_reg - SPD_A_W'(spd_qa_reg) * SPD_A_W'(VEL_DEN));
    assign spd_c_next  = SPD_C_W'({spd_ra, {TF_LO_W{1'b0}}}) + spd_b_reg;
    assign spd_qc_prod = SPD_CP_W'(spd_c_reg) * SPD_CP_W'(RCP_100);
    assign vel_mag_next = (div_count_reg == STEP_W'(1))
                        ? QUO_W'({spd_qa_reg, {TF_LO_W{1'b0}}})
                          + QUO_W'(spd_qc_prod[RCP_SH +: SPD_QC_W])
                        : vel_mag_reg;
    assign vel_mag     = vel_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_count_reg <= '0;
            spd_a_reg     <= '0;
            spd_b_reg     <= '0;
            spd_qa_reg    <= '0;
            spd_c_reg     <= '0;
            vel_mag_reg   <= MAG_RESET;
        end
        else
        begin
            div_count_reg <= div_count_next;
            spd_a_reg     <= spd_a_next;
            spd_b_reg     <= spd_b_next;
            spd_qa_reg    <= spd_qa_next;
            spd_c_reg     <= spd_c_next;
            vel_mag_reg   <= vel_mag_next;
        end
    end

    // Backward velocity: -d * mag, saturated to 32 bits
    logic signed [31:0] vel_run;

    always_comb
    begin
        if (axis_negative_reg)
            vel_run = (vel_mag > QUO_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                      : signed'(vel_mag[31:0]);
        else
            vel_run = (vel_mag >= QUO_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                       : -signed'(vel_mag[31:0]);
    end

    // ---------------- handshake and pipeline ----------------
    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_word_t  s1_word_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_word_reg;
    logic      out_free;
    logic      s1_fire;
    logic      in_fire;

    assign out_free  = !out_valid_reg || dout.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign din.ready = (!s1_valid_reg || out_free) && !div_busy && !tf_write;
    assign in_fire   = din.valid && din.ready;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_fire ? 1'b1 : (dout.ready ? 1'b0 : out_valid_reg);

    assign dout.valid = out_valid_reg;
    assign dout.data  = out_word_reg;

    // ---------------- retract state ----------------
    logic                      ret_en_reg;
    logic                      ret_en_next;
    phase_t                    ph_reg;
    phase_t                    ph_next;
    logic signed [POS_BITS-1:0] ret_end_reg;
    logic signed [POS_BITS-1:0] ret_end_next;

    // ---------------- check logic ----------------
    logic [9:0]               hb_expect;
    logic signed [CALC_W-1:0] pos_ext;
    logic signed [CALC_W-1:0] two_tf;
    logic signed [CALC_W-1:0] end_wide;
    logic signed [CALC_W-1:0] end_sat;
    logic signed [CALC_W-1:0] end_ext;
    logic                     at_end;
    out_word_t                res;
    logic [3:0]               st;
    logic                     work_en;
    phase_t                   work_ph;
    logic signed [POS_BITS-1:0] work_end;

    assign hb_expect = 10'(slave_count_reg) * 10'(HB_PER_SLAVE);
    assign pos_ext   = CALC_W'(s1_word_reg.axis_position);
    assign two_tf    = signed'(CALC_W'({transfer_factor_reg, 1'b0}));
    assign end_wide  = axis_negative_reg ? (pos_ext + two_tf) : (pos_ext - two_tf);
    assign end_sat   = (end_wide > POS_MAX) ? POS_MAX
                     : ((end_wide < POS_MIN) ? POS_MIN : end_wide);
    assign end_ext   = CALC_W'(ret_end_reg);
    // arrival: pos*d <= end*d
    assign at_end    = axis_negative_reg ? (pos_ext >= end_ext) : (pos_ext <= end_ext);

    always_comb
    begin
        st       = s1_word_reg.system_state;
        res      = '0;
        work_en  = ret_en_reg;
        work_ph  = ph_reg;
        work_end = ret_end_reg;
        res.alarm_code   = ALM_NONE;
        res.axis_command = CMD_NONE;

        if (s1_word_reg.uptime > UPTIME_MIN)
        begin
            if (s1_word_reg.heartbeat_count != hb_expect)
            begin
                st                = ST_ALARM;
                res.alarm_code    = ALM_BUS_LOST;
                res.alarm_written = 1'b1;
            end
            else
            begin
                if (!s1_word_reg.digital_inputs[DI_SHORT_N])
                begin
                    if (st == ST_IDLE_WELD)
                    begin
                        work_en           = 1'b1;
                        st                = ST_ALARM;
                        res.alarm_code    = ALM_HAND_SHORT;
                        res.alarm_written = 1'b1;
                    end
                    else if (st >= ST_PRE && st <= ST_DELAY_GAS)
                    begin
                        st                = ST_ALARM;
                        res.alarm_code    = ALM_SHORT;
                        res.alarm_written = 1'b1;
                    end
                end
                if (s1_word_reg.current_enabled && s1_word_reg.digital_inputs[DI_ARC_LOST]
                    && st >= ST_PRE && st <= ST_RUN)
                begin
                    st                = ST_ALARM;
                    res.alarm_code    = ALM_ARC_BROKEN;
                    res.alarm_written = 1'b1;
                end
                if (s1_word_reg.digital_inputs[DI_MACHINE_ERR])
                begin
                    st                = ST_ALARM;
                    res.alarm_code    = ALM_MACHINE;
                    res.alarm_written = 1'b1;
                end
                if (work_en)
                begin
                    unique case (ph_reg)
                        PH_IDLE:
                        begin
                            res.axis_command = CMD_WELD_MOVE;
                            work_ph          = PH_MOVE;
                            work_end         = end_sat[POS_BITS-1:0];
                        end
                        PH_MOVE:
                        begin
                            res.velocity_written = 1'b1;
                            if (at_end)
                            begin
                                res.axis_command = CMD_IDLE;
                                work_ph          = PH_DONE;
                                st               = ST_RESET;
                            end
                            else
                            begin
                                res.target_velocity = vel_run;
                            end
                        end
                        default:
                        begin
                            work_en = 1'b0;
                            work_ph = PH_IDLE;
                        end
                    endcase
                end
            end
        end
        res.new_system_state = st;
    end

    assign ret_en_next  = s1_fire ? work_en  : ret_en_reg;
    assign ph_next      = s1_fire ? work_ph  : ph_reg;
    assign ret_end_next = s1_fire ? work_end : ret_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ret_en_reg    <= 1'b0;
            ph_reg        <= PH_IDLE;
            ret_end_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            ret_en_reg    <= ret_en_next;
            ph_reg        <= ph_next;
            ret_end_reg   <= ret_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_word_reg <= din.data;
        if (s1_fire)
            out_word_reg <= res;
    end

`ifndef ASSERT_OFF
    // no word enters while the retract speed is being recomputed
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> !din.ready)
        else $error("word accepted during speed divide");

    // retract phases other than idle only exist with retract armed
    a_phase_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (ph_reg == PH_MOVE || ph_reg == PH_DONE) |-> ret_en_reg)
        else $error("retract phase active while disarmed");

    // arrival word: go-idle command, zero velocity written, state reset
    a_arrival: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.data.axis_command == CMD_IDLE) |->
        (dout.data.velocity_written && dout.data.target_velocity == '0
         && dout.data.new_system_state == ST_RESET))
        else $error("inconsistent retract arrival word");

    // the retract phase changes only when a word leaves the input stage
    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ph_reg != $past(ph_reg)) |-> $past(s1_fire))
        else $error("retract phase changed without a word");
`endif

endmodule

// ===== bench/tb.sv =====
module tb;
    import wfs_pkg::*;

    localparam int LIMIT_CYCLES   = 400000;
    localparam int ITEMS_PER_STEP = 200;

    // Retract sequence phases as the supervisor walks them
    typedef enum logic [1:0] {RT_IDLE, RT_MOVING, RT_FINISHED} rt_phase_t;

    // One row of the directed table: a tick word, and the result typed in
    // by hand where it is obvious; otherwise the predictor supplies it.
    typedef struct {
        in_word_t  stim;
        bit        typed;
        out_word_t want;
    } tick_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    wfs_in_if  din_if ();
    wfs_out_if dout_if ();

    weld_fault_supervisor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .din       (din_if),
        .dout      (dout_if)
    );

    // Shadow copy of the registers, loaded with their reset values
    logic [SC_W-1:0] sc_shadow  = SC_RESET;
    logic [TF_W-1:0] tf_shadow  = TF_RESET;
    logic            neg_shadow = 1'b0;

    // Shadow copy of the retract state
    logic      rt_armed = 1'b0;
    rt_phase_t rt_phase = RT_IDLE;
    longint    rt_end   = 0;

    out_word_t tick_outcomes[$];
    tick_row_t tick_table[$];

    int  cycle_cnt   = 0;
    int  n_fail      = 0;
    int  n_sent      = 0;
    int  n_checked   = 0;
    int  n_alarms    = 0;
    int  n_arrivals  = 0;
    int  n_settings  = 1;
    int  gap_pct     = 15;
    int  stall_pct   = 15;
    int  sink_stall  = 0;
    bit  calm        = 1'b0;
    out_word_t want_word;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    // Watchdog: a hung handshake ends the run here
    initial
    begin
        wait (cycle_cnt >= LIMIT_CYCLES);
        $error("timeout after %0d cycles, %0d results still due", cycle_cnt,
               tick_outcomes.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint clamp_s32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Predict one control tick: fault checks in priority order, then one step
    // of the retract sequence. Updates the shadow retract state.
    function automatic out_word_t supervise_tick(in_word_t w);
        out_word_t  r;
        logic [3:0] st;
        longint     pos;
        longint     dir;
        longint     tf;
        r   = '0;
        st  = w.system_state;
        pos = $signed(w.axis_position);
        dir = neg_shadow ? -64'sd1 : 64'sd1;
        tf  = longint'(tf_shadow);
        if (w.uptime > UPTIME_MIN)
        begin
            if (int'(w.heartbeat_count) != int'(sc_shadow) * HB_PER_SLAVE)
            begin
                // bus lost ends the tick; the retract does not advance
                st = ST_ALARM;
                r.alarm_code    = ALM_BUS_LOST;
                r.alarm_written = 1'b1;
            end
            else
            begin
                if (!w.digital_inputs[DI_SHORT_N])
                begin
                    if (st == ST_IDLE_WELD)
                    begin
                        rt_armed        = 1'b1;
                        st              = ST_ALARM;
                        r.alarm_code    = ALM_HAND_SHORT;
                        r.alarm_written = 1'b1;
                    end
                    else if (st >= ST_PRE && st <= ST_DELAY_GAS)
                    begin
                        st              = ST_ALARM;
                        r.alarm_code    = ALM_SHORT;
                        r.alarm_written = 1'b1;
                    end
                end
                // arc check sees the state the short check left behind
                if (w.current_enabled && w.digital_inputs[DI_ARC_LOST] &&
                    st >= ST_PRE && st <= ST_RUN)
                begin
                    st              = ST_ALARM;
                    r.alarm_code    = ALM_ARC_BROKEN;
                    r.alarm_written = 1'b1;
                end
                if (w.digital_inputs[DI_MACHINE_ERR])
                begin
                    st              = ST_ALARM;
                    r.alarm_code    = ALM_MACHINE;
                    r.alarm_written = 1'b1;
                end
                if (rt_armed)
                begin
                    case (rt_phase)
                        RT_IDLE:
                        begin
                            r.axis_command = CMD_WELD_MOVE;
                            rt_phase       = RT_MOVING;
                            rt_end         = clamp_s32(pos - 2 * tf * dir);
                        end
                        RT_MOVING:
                        begin
                            r.velocity_written = 1'b1;
                            if (pos * dir <= rt_end * dir)
                            begin
                                r.axis_command = CMD_IDLE;
                                rt_phase       = RT_FINISHED;
                                st             = ST_RESET;
                                n_arrivals++;
                            end
                            else
                            begin
                                r.target_velocity = 32'(clamp_s32(
                                    -dir * ((tf * VEL_NUM + VEL_RND) / VEL_DEN)));
                            end
                        end
                        default:
                        begin
                            rt_armed = 1'b0;
                            rt_phase = RT_IDLE;
                        end
                    endcase
                end
            end
        end
        if (r.alarm_written)
            n_alarms++;
        r.new_system_state = st;
        return r;
    endfunction

    function automatic in_word_t mk_in(logic [31:0] up, logic [9:0] hb, logic [15:0] di,
                                       logic cur, logic [3:0] st, logic [31:0] pos);
        in_word_t w;
        w.uptime          = up;
        w.heartbeat_count = hb;
        w.digital_inputs  = di;
        w.current_enabled = cur;
        w.system_state    = st;
        w.axis_position   = pos;
        return w;
    endfunction

    function automatic out_word_t mk_out(logic [3:0] st, logic [2:0] alarm, logic aw);
        out_word_t r;
        r                  = '0;
        r.new_system_state = st;
        r.alarm_code       = alarm;
        r.alarm_written    = aw;
        return r;
    endfunction

    task automatic add_row(in_word_t w, bit typed, out_word_t o);
        tick_row_t row;
        row.stim  = w;
        row.typed = typed;
        row.want  = o;
        tick_table.push_back(row);
    endtask

    // Random tick: mostly healthy heartbeat and uptime so the checks and the
    // retract get exercised; positions are steered toward the retract end
    // point while a retract is moving so arrivals happen.
    function automatic in_word_t rand_tick();
        in_word_t w;
        case ($urandom_range(9))
            0:       w.uptime = $urandom_range(0, 2);
            1:       w.uptime = $urandom;
            default: w.uptime = $urandom_range(3, 100000);
        endcase
        if ($urandom_range(9) < 8)
            w.heartbeat_count = 10'(int'(sc_shadow) * HB_PER_SLAVE);
        else
            w.heartbeat_count = 10'($urandom);
        w.digital_inputs = 16'($urandom);
        if ($urandom_range(3) != 0)
            w.digital_inputs[DI_MACHINE_ERR] = 1'b0;
        w.current_enabled = 1'($urandom);
        if ($urandom_range(9) < 3)
            w.system_state = ST_IDLE_WELD;
        else
            w.system_state = 4'($urandom_range(0, 15));
        if (rt_phase == RT_MOVING && $urandom_range(1) == 1)
            w.axis_position = 32'(rt_end) + 32'($urandom_range(0, 6)) - 32'd3;
        else if ($urandom_range(2) == 0)
            w.axis_position = 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
        else
            w.axis_position = $urandom;
        return w;
    endfunction

    // Offer one word; the predictor runs at the edge it is taken
    task automatic push_tick(in_word_t w, bit typed, out_word_t typed_out);
        out_word_t pred;
        if (!calm && gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            din_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        din_if.valid <= 1'b1;
        din_if.data  <= w;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        pred = supervise_tick(w);
        tick_outcomes.push_back(typed ? typed_out : pred);
        n_sent++;
    endtask

    // Hold off the sender until every result due has come back
    task automatic drain();
        din_if.valid <= 1'b0;
        @(posedge clk);
        while (tick_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Registers change only with the block idle: drained and settled
    task automatic apply_settings(logic [SC_W-1:0] sc, logic [TF_W-1:0] tf, logic neg);
        drain();
        repeat (4) @(posedge clk);
        write_reg(CFG_SLAVE_COUNT, CFG_W'(sc));
        write_reg(CFG_TRANSFER_FACTOR, CFG_W'(tf));
        write_reg(CFG_AXIS_NEGATIVE, CFG_W'(neg));
        cfg_we     <= 1'b0;
        sc_shadow  = sc;
        tf_shadow  = tf;
        neg_shadow = neg;
        n_settings++;
    endtask

    task automatic check_field(string fname, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            n_fail++;
        end
    endtask

    // Result sink: random stall bursts, none once the run turns calm
    always @(posedge clk)
    begin
        if (sink_stall > 0)
            sink_stall--;
        else if (!calm && stall_pct != 0 && $urandom_range(99) < stall_pct)
            sink_stall = $urandom_range(1, 11);
        dout_if.ready <= (sink_stall == 0);
    end

    // Compare each taken result word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (tick_outcomes.size() == 0)
            begin
                $error("result word with no tick outstanding");
                n_fail++;
            end
            else
            begin
                want_word = tick_outcomes.pop_front();
                n_checked++;
                check_field("new_system_state", want_word.new_system_state,
                            dout_if.data.new_system_state);
                check_field("alarm_code", want_word.alarm_code, dout_if.data.alarm_code);
                check_field("alarm_written", want_word.alarm_written,
                            dout_if.data.alarm_written);
                check_field("axis_command", want_word.axis_command,
                            dout_if.data.axis_command);
                check_field("velocity_written", want_word.velocity_written,
                            dout_if.data.velocity_written);
                check_field("target_velocity", $signed(want_word.target_velocity),
                            $signed(dout_if.data.target_velocity));
            end
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_wdata    <= '0;
        din_if.valid <= 1'b0;
        din_if.data  <= '0;

        // Directed table, reset settings: slave_count 1 (heartbeat 3),
        // transfer unit 1.0, positive axis.
        // uptime gate: nothing happens at 2 or below, whatever the inputs
        add_row(mk_in(32'd0, 10'd0, 16'h0000, 1'b0, ST_RUN, 32'd0), 1'b1,
                mk_out(ST_RUN, ALM_NONE, 1'b0));
        add_row(mk_in(32'd2, 10'd1023, 16'hFFFF, 1'b1, 4'd15, 32'h8000_0000), 1'b1,
                mk_out(4'd15, ALM_NONE, 1'b0));
        // heartbeat loss, including one that masks a hand short
        add_row(mk_in(32'd3, 10'd0, 16'h0040, 1'b0, ST_RUN, 32'd0), 1'b1,
                mk_out(ST_ALARM, ALM_BUS_LOST, 1'b1));
        add_row(mk_in(32'hFFFF_FFFF, 10'd1023, 16'hFFBF, 1'b1, ST_IDLE_WELD,
                      32'h7FFF_FFFF), 1'b1, mk_out(ST_ALARM, ALM_BUS_LOST, 1'b1));
        // healthy tick
        add_row(mk_in(32'd3, 10'd3, 16'h0040, 1'b0, ST_RUN, 32'd0), 1'b1,
                mk_out(ST_RUN, ALM_NONE, 1'b0));
        // short circuit in weld states, ignored in other and undefined states
        add_row(mk_in(32'd3, 10'd3, 16'h0000, 1'b0, ST_RUN, 32'd0), 1'b1,
                mk_out(ST_ALARM, ALM_SHORT, 1'b1));
        add_row(mk_in(32'd3, 10'd3, 16'h4000, 1'b1, ST_DELAY_GAS, 32'd0), 1'b1,
                mk_out(ST_ALARM, ALM_SHORT, 1'b1));
        add_row(mk_in(32'd3, 10'd3, 16'h0000, 1'b0, 4'd0, 32'd0), 1'b1,
                mk_out(4'd0, ALM_NONE, 1'b0));
        add_row(mk_in(32'd3, 10'd3, 16'h0000, 1'b1, 4'd12, 32'd0), 1'b1,
                mk_out(4'd12, ALM_NONE, 1'b0));
        // arc broken needs current enabled
        add_row(mk_in(32'd3, 10'd3, 16'h4040, 1'b1, 4'd3, 32'd0), 1'b1,
                mk_out(ST_ALARM, ALM_ARC_BROKEN, 1'b1));
        add_row(mk_in(32'd3, 10'd3, 16'h4040, 1'b0, 4'd3, 32'd0), 1'b1,
                mk_out(4'd3, ALM_NONE, 1'b0));
        // machine error, and several faults at once: the last alarm wins
        add_row(mk_in(32'd3, 10'd3, 16'h0060, 1'b0, 4'd0, 32'd0), 1'b1,
                mk_out(ST_ALARM, ALM_MACHINE, 1'b1));
        add_row(mk_in(32'd3, 10'd3, 16'h4020, 1'b1, ST_PRE, 32'd0), 1'b1,
                mk_out(ST_ALARM, ALM_MACHINE, 1'b1));
        add_row(mk_in(32'd3, 10'd3, 16'hFFFF, 1'b1, ST_RESET, 32'd0), 1'b1,
                mk_out(ST_ALARM, ALM_MACHINE, 1'b1));
        // hand short arms the retract; bus loss and a low uptime freeze it
        add_row(mk_in(32'd3, 10'd3, 16'h0000, 1'b0, ST_IDLE_WELD, 32'd0), 1'b0, '0);
        add_row(mk_in(32'd100, 10'd0, 16'h0040, 1'b0, ST_ALARM, 32'd0), 1'b1,
                mk_out(ST_ALARM, ALM_BUS_LOST, 1'b1));
        add_row(mk_in(32'd1, 10'd3, 16'h0040, 1'b0, ST_ALARM, 32'd0), 1'b1,
                mk_out(ST_ALARM, ALM_NONE, 1'b0));
        // moving, one LSB short of the end, then arrival and wind-down
        add_row(mk_in(32'd4, 10'd3, 16'h0040, 1'b0, ST_ALARM, 32'd0), 1'b0, '0);
        add_row(mk_in(32'd5, 10'd3, 16'h0040, 1'b0, ST_ALARM, 32'hFFFE_0001), 1'b0, '0);
        add_row(mk_in(32'd6, 10'd3, 16'h0040, 1'b0, ST_ALARM, 32'hFFFE_0000), 1'b0, '0);
        add_row(mk_in(32'd7, 10'd3, 16'h0040, 1'b0, ST_RESET, 32'd0), 1'b0, '0);
        add_row(mk_in(32'd8, 10'd3, 16'h0040, 1'b0, ST_RESET, 32'd0), 1'b0, '0);
        // hand short plus machine error at the top of the position range,
        // then arrival from the bottom of it
        add_row(mk_in(32'd9, 10'd3, 16'h0020, 1'b0, ST_IDLE_WELD, 32'h7FFF_FFFF), 1'b0, '0);
        add_row(mk_in(32'd10, 10'd3, 16'h0040, 1'b1, ST_RUN, 32'h8000_0000), 1'b0, '0);
        add_row(mk_in(32'd11, 10'd3, 16'h0040, 1'b0, ST_RESET, 32'd0), 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (tick_table[i])
            push_tick(tick_table[i].stim, tick_table[i].typed, tick_table[i].want);

        // Random part: one block of ticks per register setting. Extremes
        // first, one block with no idling, then random settings; the last
        // block runs with no gaps and no stalls.
        for (int step = 0; step < 8; step++)
        begin
            case (step)
                0: apply_settings(8'd0, 31'd0, 1'b1);
                1: apply_settings(8'd255, 31'h7FFF_FFFF, 1'b0);
                2: apply_settings(8'd255, 31'h7FFF_FFFF, 1'b1);
                3: apply_settings(SC_RESET, TF_RESET, 1'b0);
                default: apply_settings(8'($urandom), 31'($urandom_range(0, 32'h0010_0000)),
                                        1'($urandom));
            endcase
            gap_pct   = (step == 3) ? 0 : $urandom_range(5, 30);
            stall_pct = (step == 3) ? 0 : $urandom_range(5, 30);
            calm      = (step == 7);
            for (int k = 0; k < ITEMS_PER_STEP; k++)
            begin
                if (k == ITEMS_PER_STEP / 2)
                    drain();
                push_tick(rand_tick(), 1'b0, '0);
            end
        end

        din_if.valid <= 1'b0;
        while (tick_outcomes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d ticks under %0d register settings, checked %0d results.",
                 n_sent, n_settings, n_checked);
        $display("Predicted %0d alarm ticks and %0d retract arrivals.", n_alarms, n_arrivals);
        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
